// File: hdl/uvs_pkg.sv
package uvs_pkg;

    localparam int MAX_COLUMNS_DEF     = 4096;
    localparam int MAX_ROWS_DEF        = 2048;
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int ANGLE_BITS_DEF      = 16;

    localparam int CORDIC_STAGES = 30;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_X_FACES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FACES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SUBFACES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SUBFACES = 2'd3;

    // Divider works on a 30-bit dividend against a 13-bit count.
    localparam int DIV_N_W = 30;
    localparam int CNT_W   = 13;

    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
            3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
            6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
            9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
            12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
            15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
            18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
            21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
            24: t = 34'sd41;        25: t = 34'sd20;        26: t = 34'sd10;
            27: t = 34'sd5;         28: t = 34'sd3;         29: t = 34'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic [12:0]      col;
        logic [11:0]      row;
        logic [CNT_W-1:0] cols;
        logic [CNT_W-1:0] rows;
        logic             err;
    } t_job;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        err;
    } t_res;

endpackage

// File: hdl/uvs_front.sv
module uvs_front import uvs_pkg::*; #(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [12:0]          i_column_index,
    input  logic [11:0]          i_row_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_job                 o_job
);
    logic [8:0] r_xf;
    logic [7:0] r_yf;
    logic [4:0] r_xs, r_ys;
    logic       r_valid;
    t_job       r_job, n_job;
    logic [13:0] cols_raw, rows_raw;
    logic [8:0]  xf_c;
    logic [7:0]  yf_c;
    logic [4:0]  xs_c, ys_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xf <= 9'd8; r_yf <= 8'd6; r_xs <= 5'd4; r_ys <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_FACES:    r_xf <= i_cfg_data;
                REG_Y_FACES:    r_yf <= i_cfg_data[7:0];
                REG_X_SUBFACES: r_xs <= i_cfg_data[4:0];
                REG_Y_SUBFACES: r_ys <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        xf_c = (r_xf == 9'd0) ? 9'd1 : ((r_xf > 9'd256) ? 9'd256 : r_xf);
        yf_c = (r_yf == 8'd0) ? 8'd1 : ((r_yf > 8'd128) ? 8'd128 : r_yf);
        xs_c = (r_xs == 5'd0) ? 5'd1 : ((r_xs > 5'd16) ? 5'd16 : r_xs);
        ys_c = (r_ys == 5'd0) ? 5'd1 : ((r_ys > 5'd16) ? 5'd16 : r_ys);
        cols_raw = 14'(xf_c) * 14'(xs_c);
        rows_raw = 14'(yf_c) * 14'(ys_c);
        n_job.col  = i_column_index;
        n_job.row  = i_row_index;
        n_job.cols = ({18'd0, cols_raw} > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) :
                     cols_raw[CNT_W-1:0];
        n_job.rows = ({18'd0, rows_raw} > MAX_ROWS) ? CNT_W'(MAX_ROWS) :
                     rows_raw[CNT_W-1:0];
        n_job.err  = ({1'b0, i_column_index} > {1'b0, n_job.cols}) ||
                     ({2'b0, i_row_index} > {1'b0, n_job.rows});
    end

    // Single register stage; hold while downstream stalls.
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (!o_stall) r_valid <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule

// File: hdl/uvs_fifo.sv
module uvs_fifo import uvs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_job o_job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push = i_valid && !o_stall;
    assign pop  = o_valid && !i_stall;
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end
endmodule

// File: hdl/uvs_back.sv
module uvs_back import uvs_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);
    // Stages: load, NQ restoring divider steps, seed, CORDIC, quadrant fold, then multiply, round.
    localparam int NQ   = (DIV_N_W > CNT_W + ANGLE_BITS) ? DIV_N_W : CNT_W + ANGLE_BITS;
    localparam int CS   = CORDIC_STAGES;
    localparam int NST  = NQ + 1 + CS + 1 + 3;
    localparam logic signed [47:0] LIM = 48'sd1 <<< COORD_FRAC_BITS;

    typedef struct packed {
        logic [NQ-1:0]    na;    // azimuth dividend / quotient
        logic [NQ-1:0]    np;
        logic [NQ-1:0]    nu;
        logic [NQ-1:0]    nv;
        logic [CNT_W:0]   ra, rp, ru, rv;  // partial remainders
        logic [CNT_W-1:0] cols, rows;
        logic             err;
    } t_div;

    typedef struct packed {
        logic signed [33:0] xa, ya, za, xp, yp, zp;
        logic [1:0]         qa, qp;
        logic [16:0]        u, v;
        logic               err;
    } t_cor;

    logic adv;
    logic [NST-1:0] r_vld;
    t_div r_d [NQ+1];
    t_cor r_c [CS+1];
    logic signed [33:0] r_ca, r_sa, r_cp, r_sp;
    logic [16:0] r_u1, r_v1, r_u2, r_v2;
    logic        r_e1, r_e2;
    logic signed [67:0] r_mx, r_mz;
    logic signed [33:0] r_cp2;
    t_res r_res;

    assign o_stall = !adv;
    assign adv = !(r_vld[NST-1] && i_stall);
    assign o_valid = r_vld[NST-1];
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[NST-2:0], i_valid};
    end

    function automatic logic [31:0] phase_of(input logic [NQ-1:0] q);
        logic [ANGLE_BITS-1:0] a;
        a = q[ANGLE_BITS-1:0];
        return {a, {(32-ANGLE_BITS){1'b0}}};
    endfunction

    function automatic logic signed [33:0] shf(input logic signed [33:0] v, input int s);
        return v >>> s;
    endfunction

    // Divider load: dividend with rounding term, bits enter MSB first.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d[0].na <= (NQ'(i_job.col) << ANGLE_BITS) + NQ'(i_job.cols >> 1);
            r_d[0].np <= (NQ'(i_job.row) << (ANGLE_BITS-1)) + NQ'(i_job.rows >> 1);
            r_d[0].nu <= (NQ'(i_job.col) << 16) + NQ'(i_job.cols >> 1);
            r_d[0].nv <= (NQ'(i_job.row) << 16) + NQ'(i_job.rows >> 1);
            r_d[0].ra <= '0; r_d[0].rp <= '0; r_d[0].ru <= '0; r_d[0].rv <= '0;
            r_d[0].cols <= i_job.cols; r_d[0].rows <= i_job.rows;
            r_d[0].err <= i_job.err;
        end
    end

    for (genvar g = 0; g < NQ; g++) begin : g_div
        function automatic logic [CNT_W+NQ:0] dstep(input logic [CNT_W:0] r,
                                                   input logic [NQ-1:0] n,
                                                   input logic [CNT_W-1:0] d);
            logic [CNT_W+1:0] t;
            logic [NQ-1:0]    nn;
            t  = {r, n[NQ-1]};
            nn = {n[NQ-2:0], 1'b0};
            if (t >= {2'b0, d}) begin
                t = t - {2'b0, d};
                nn[0] = 1'b1;
            end
            return {t[CNT_W:0], nn};
        endfunction
        always_ff @(posedge i_clk) begin
            if (adv) begin
                {r_d[g+1].ra, r_d[g+1].na} <= dstep(r_d[g].ra, r_d[g].na, r_d[g].cols);
                {r_d[g+1].rp, r_d[g+1].np} <= dstep(r_d[g].rp, r_d[g].np, r_d[g].rows);
                {r_d[g+1].ru, r_d[g+1].nu} <= dstep(r_d[g].ru, r_d[g].nu, r_d[g].cols);
                {r_d[g+1].rv, r_d[g+1].nv} <= dstep(r_d[g].rv, r_d[g].nv, r_d[g].rows);
                r_d[g+1].cols <= r_d[g].cols;
                r_d[g+1].rows <= r_d[g].rows;
                r_d[g+1].err  <= r_d[g].err;
            end
        end
    end

    // Quarter reduction and CORDIC seed.
    logic [31:0] pha, php;
    logic [2:0]  qa3, qp3;
    assign pha = phase_of(r_d[NQ].na);
    assign php = phase_of(r_d[NQ].np);
    assign qa3 = 3'(({1'b0, pha} + 33'h20000000) >> 30);
    assign qp3 = 3'(({1'b0, php} + 33'h20000000) >> 30);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c[0].xa <= CORDIC_START; r_c[0].ya <= '0;
            r_c[0].za <= $signed({2'b0, pha}) - $signed({qa3[1:0] == 2'd0 && qa3[2] ?
                          34'h100000000 : {qa3, 30'd0}} & 34'h3FFFFFFFF);
            r_c[0].xp <= CORDIC_START; r_c[0].yp <= '0;
            r_c[0].zp <= $signed({2'b0, php}) - $signed({qp3[1:0] == 2'd0 && qp3[2] ?
                          34'h100000000 : {qp3, 30'd0}} & 34'h3FFFFFFFF);
            r_c[0].qa <= qa3[1:0]; r_c[0].qp <= qp3[1:0];
            r_c[0].u <= r_d[NQ].nu[16:0]; r_c[0].v <= r_d[NQ].nv[16:0];
            r_c[0].err <= r_d[NQ].err;
        end
    end

    for (genvar s = 0; s < CS; s++) begin : g_cor
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_c[s].za[33]) begin
                    r_c[s+1].xa <= r_c[s].xa - shf(r_c[s].ya, s);
                    r_c[s+1].ya <= r_c[s].ya + shf(r_c[s].xa, s);
                    r_c[s+1].za <= r_c[s].za - atan_turn(s);
                end else begin
                    r_c[s+1].xa <= r_c[s].xa + shf(r_c[s].ya, s);
                    r_c[s+1].ya <= r_c[s].ya - shf(r_c[s].xa, s);
                    r_c[s+1].za <= r_c[s].za + atan_turn(s);
                end
                if (!r_c[s].zp[33]) begin
                    r_c[s+1].xp <= r_c[s].xp - shf(r_c[s].yp, s);
                    r_c[s+1].yp <= r_c[s].yp + shf(r_c[s].xp, s);
                    r_c[s+1].zp <= r_c[s].zp - atan_turn(s);
                end else begin
                    r_c[s+1].xp <= r_c[s].xp + shf(r_c[s].yp, s);
                    r_c[s+1].yp <= r_c[s].yp - shf(r_c[s].xp, s);
                    r_c[s+1].zp <= r_c[s].zp + atan_turn(s);
                end
                r_c[s+1].qa <= r_c[s].qa; r_c[s+1].qp <= r_c[s].qp;
                r_c[s+1].u <= r_c[s].u; r_c[s+1].v <= r_c[s].v;
                r_c[s+1].err <= r_c[s].err;
            end
        end
    end

    function automatic logic signed [33:0] clq(input logic signed [33:0] v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    logic signed [33:0] ca, sa, cp, sp;
    always_comb begin
        case (r_c[CS].qa)
            2'd0: begin ca = r_c[CS].xa;  sa = r_c[CS].ya;  end
            2'd1: begin ca = -r_c[CS].ya; sa = r_c[CS].xa;  end
            2'd2: begin ca = -r_c[CS].xa; sa = -r_c[CS].ya; end
            default: begin ca = r_c[CS].ya; sa = -r_c[CS].xa; end
        endcase
        case (r_c[CS].qp)
            2'd0: begin cp = r_c[CS].xp;  sp = r_c[CS].yp;  end
            2'd1: begin cp = -r_c[CS].yp; sp = r_c[CS].xp;  end
            2'd2: begin cp = -r_c[CS].xp; sp = -r_c[CS].yp; end
            default: begin cp = r_c[CS].yp; sp = -r_c[CS].xp; end
        endcase
    end

    function automatic logic [15:0] fin(input logic signed [67:0] p, input int sh);
        logic signed [67:0] t;
        t = (p + (68'sd1 <<< (sh-1))) >>> sh;
        if (t > 68'(LIM)) t = 68'(LIM);
        if (t < -68'(LIM)) t = -68'(LIM);
        return t[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ca <= clq(ca); r_sa <= clq(sa); r_cp <= clq(cp); r_sp <= clq(sp);
            r_u1 <= r_c[CS].u; r_v1 <= r_c[CS].v; r_e1 <= r_c[CS].err;
            // Products of 31-bit magnitudes.
            r_mx <= r_sp * r_ca;
            r_mz <= r_sp * r_sa;
            r_cp2 <= r_cp;
            r_u2 <= r_u1; r_v2 <= r_v1; r_e2 <= r_e1;
            if (r_e2) begin
                r_res.pos_x <= '0;
                r_res.pos_z <= '0;
                r_res.pos_y <= '0;
                r_res.tex_u <= '0;
                r_res.tex_v <= '0;
                r_res.err   <= 1'b1;
            end else begin
                r_res.pos_x <= fin(r_mx, 60 - COORD_FRAC_BITS);
                r_res.pos_z <= fin(r_mz, 60 - COORD_FRAC_BITS);
                r_res.pos_y <= fin(68'(r_cp2), 30 - COORD_FRAC_BITS);
                r_res.tex_u <= r_u2;
                r_res.tex_v <= r_v2;
                r_res.err   <= 1'b0;
            end
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.err) |-> (o_res.tex_u == '0 && o_res.tex_v == '0))
        else $error("error word with nonzero texture");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("result changed under stall");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.tex_u <= 17'h10000))
        else $error("texture u out of range");
endmodule

// File: hdl/uv_sphere_vertex_generator_unit.sv
// UV sphere vertex generator: each (column, row) word yields one unit-sphere vertex in Q1.14
// and texture coordinates in Q1.16, one word per clock sustained while the output is not
// stalled. A front stage registers the index pair with the grid counts from the
// configuration registers and flags indices beyond their count; a four-entry queue
// decouples it from the back pipeline, which runs 30 restoring-divider stages for the
// angle phases and texture coordinates, 30 CORDIC stages for sine and cosine, then
// quadrant, product and rounding stages. An input word passes one front stage, one queue
// stage and the back stages. Write configuration only while the block is idle.
module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS        = MAX_ROWS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [12:0]          i_column_index,
    input  logic [11:0]          i_row_index,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_pos_x,
    output logic [15:0]          o_pos_y,
    output logic [15:0]          o_pos_z,
    output logic [16:0]          o_tex_u,
    output logic [16:0]          o_tex_v,
    output logic                 o_index_error
);
    logic f_valid, f_stall, q_valid, q_stall;
    t_job f_job, q_job;
    t_res res;

    // Front: register the word and classify it.
    uvs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_column_index, .i_row_index,
        .o_valid(f_valid), .i_stall(f_stall), .o_job(f_job)
    );

    // Queue: absorb back-end stalls.
    uvs_fifo #(.DEPTH(4)) u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_job(f_job),
        .o_valid(q_valid), .i_stall(q_stall), .o_job(q_job)
    );

    // Back: divide, rotate, multiply, round.
    uvs_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_stall(q_stall), .i_job(q_job),
        .o_valid, .i_stall, .o_res(res)
    );

    assign o_pos_x       = res.pos_x;
    assign o_pos_y       = res.pos_y;
    assign o_pos_z       = res.pos_z;
    assign o_tex_u       = res.tex_u;
    assign o_tex_v       = res.tex_v;
    assign o_index_error = res.err;
endmodule
